### rtl/zasm_pkg.sv
// Shared types and codes for the zero-address stack machine.
// Opcodes, result status codes and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package zasm_pkg;

   // Instruction codes carried on req_type; code 7 has no meaning
   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_POP  = 3'd1,
      OP_ADD  = 3'd2,
      OP_MUL  = 3'd3,
      OP_END  = 3'd4,
      OP_LOAD = 3'd5,
      OP_READ = 3'd6
   } op_type;

   // Result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_UNDER  = 2'd1;
   localparam logic [1:0] ST_OVER   = 2'd2;
   localparam logic [1:0] ST_HALTED = 2'd3;

   // Controller to datapath
   typedef struct packed {
      logic latch;        // capture the accepted request
      logic commit;       // update machine state and load the result register
      logic use_product;  // take the new top from the product register
      logic clear_step;   // zero one data-memory word and advance the sweep
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic mul_go;       // held item is a multiply that will execute
      logic clear_done;   // sweep is at the last data-memory word
   } sts_type;

endpackage

`default_nettype wire

### rtl/zero_address_stack_machine_unit.sv
// Top level of the zero-address stack machine: controller plus datapath.
// Depends on zasm_pkg, zasm_ctrl and zasm_datapath.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   req_type, req_mem_address, req_load_value
//   rsp_      out        rsp_valid/rsp_ready   rsp_result_value, rsp_stack_depth,
//                                              rsp_status, rsp_halted
//
// An item passes capture, memory read and execute steps from transfer to result;
// a multiply that executes adds a further step for the registered multiplier.
// After reset the data memory is zeroed by a sweep over all MEM_WORDS words; req_ready
// stays low during it. A new item is accepted while a result waits on rsp_ready;
// that item then holds in its execute or multiply step until the result register frees.
`timescale 1ns / 1ps
`default_nettype none

module zero_address_stack_machine_unit
   import zasm_pkg::*;
#(
   parameter int STACK_DEPTH = 64,
   parameter int MEM_WORDS   = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_type,
   input  wire logic [7:0]         req_mem_address,
   input  wire logic signed [31:0] req_load_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_result_value,
   output logic [6:0]              rsp_stack_depth,
   output logic [1:0]              rsp_status,
   output logic                    rsp_halted
);

   cmd_type cmd;
   sts_type sts;

   zasm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   zasm_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .MEM_WORDS   (MEM_WORDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_mem_address  (req_mem_address),
      .req_load_value   (req_load_value),
      .rsp_result_value (rsp_result_value),
      .rsp_stack_depth  (rsp_stack_depth),
      .rsp_status       (rsp_status),
      .rsp_halted       (rsp_halted)
   );

endmodule

`default_nettype wire

### rtl/zasm_datapath.sv
// Datapath of the stack machine: item registers, stack and data memories,
// top-of-stack register, adder, multiplier and result register.
// Depends on zasm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zasm_datapath
   import zasm_pkg::*;
#(
   parameter int STACK_DEPTH = 64,
   parameter int MEM_WORDS   = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output sts_type                 sts,
   input  wire logic [2:0]         req_type,
   input  wire logic [7:0]         req_mem_address,
   input  wire logic signed [31:0] req_load_value,
   output logic signed [31:0]      rsp_result_value,
   output logic [6:0]              rsp_stack_depth,
   output logic [1:0]              rsp_status,
   output logic                    rsp_halted
);

   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int XW = (AW > 8) ? AW : 8;
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int DW = (CW > 7) ? CW : 7;

   // Reduce an 8-bit address modulo MEM_WORDS by restoring subtraction
   function automatic logic [7:0] wrap_address(input logic [7:0] a);
      logic [7:0] v;
      v = a;
      for (int i = 7; i >= 0; i--) begin
         if (int'(v) >= (MEM_WORDS << i)) begin
            v = v - 8'(MEM_WORDS << i);
         end
      end
      return v;
   endfunction

   // Held item
   logic [2:0]    op_ff;
   logic [AW-1:0] addr_ff;
   logic [31:0]   ldv_ff;
   logic [XW-1:0] addr_ext;

   // Machine state
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   tos_ff, tos_in;
   logic          halt_ff, halt_in;
   logic [AW-1:0] clr_ff;

   // Memories and their registered read data
   logic [31:0]   dmem [MEM_WORDS];
   logic [31:0]   stk [STACK_DEPTH];
   logic [31:0]   dmem_rd_ff;
   logic [31:0]   stk_rd_ff;
   logic [31:0]   prod_ff;

   // Commit-cycle controls
   logic          dmem_we;
   logic [31:0]   dmem_wd;
   logic          stk_we;
   logic [SW-1:0] stk_wa;
   logic [SW-1:0] stk_ra;
   logic [CW-1:0] count_m1;
   logic [CW-1:0] count_m2;
   logic          is_read;
   logic [1:0]    status_in;
   logic [31:0]   result_in;
   logic [DW-1:0] depth_ext;

   // Result register
   logic [31:0]   res_value_ff;
   logic [6:0]    res_depth_ff;
   logic [1:0]    res_status_ff;
   logic          res_halted_ff;

   assign addr_ext = XW'(wrap_address(req_mem_address));
   assign count_m1 = count_ff - CW'(1);
   assign count_m2 = count_ff - CW'(2);
   assign stk_wa   = count_m1[SW-1:0];
   assign stk_ra   = count_m2[SW-1:0];

   // Capture the accepted request
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_type;
         addr_ff <= addr_ext[AW-1:0];
         ldv_ff  <= $unsigned(req_load_value);
      end
   end

   // Work out the effect of the held item
   always_comb begin
      count_in  = count_ff;
      tos_in    = tos_ff;
      halt_in   = halt_ff;
      dmem_we   = 1'b0;
      dmem_wd   = tos_ff;
      stk_we    = 1'b0;
      is_read   = 1'b0;
      status_in = ST_OK;
      case (op_ff)
         OP_LOAD: begin
            dmem_we = 1'b1;
            dmem_wd = ldv_ff;
         end
         OP_READ: begin
            is_read = 1'b1;
         end
         default: begin
            if (halt_ff) begin
               status_in = ST_HALTED;
            end else begin
               case (op_ff)
                  OP_PUSH: begin
                     if (count_ff == CW'(STACK_DEPTH)) begin
                        status_in = ST_OVER;
                     end else begin
                        // spill the old top below the new one
                        stk_we   = (count_ff != '0);
                        tos_in   = dmem_rd_ff;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = ST_UNDER;
                     end else begin
                        dmem_we  = 1'b1;
                        dmem_wd  = tos_ff;
                        tos_in   = stk_rd_ff;
                        count_in = count_m1;
                     end
                  end
                  OP_ADD, OP_MUL: begin
                     if (count_ff < CW'(2)) begin
                        status_in = ST_UNDER;
                     end else begin
                        tos_in   = cmd.use_product ? prod_ff : tos_ff + stk_rd_ff;
                        count_in = count_m1;
                     end
                  end
                  OP_END: begin
                     halt_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
      endcase
      depth_ext = DW'(count_in);
      if (is_read) begin
         result_in = dmem_rd_ff;
      end else if (count_in == '0) begin
         result_in = '0;
      end else begin
         result_in = tos_in;
      end
   end

   // Hold machine state; advance it on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         halt_ff  <= 1'b0;
         clr_ff   <= '0;
      end else begin
         if (cmd.commit) begin
            count_ff <= count_in;
            halt_ff  <= halt_in;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         tos_ff        <= tos_in;
         res_value_ff  <= result_in;
         res_depth_ff  <= depth_ext[6:0];
         res_status_ff <= status_in;
         res_halted_ff <= halt_in;
      end
   end

   // Data memory: clearing sweep after reset, one write port, one registered read
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         dmem[clr_ff] <= '0;
      end else if (cmd.commit && dmem_we) begin
         dmem[addr_ff] <= dmem_wd;
      end
      dmem_rd_ff <= dmem[addr_ff];
   end

   // Stack memory holds every entry below the top
   always_ff @(posedge clock) begin
      if (cmd.commit && stk_we) begin
         stk[stk_wa] <= tos_ff;
      end
      stk_rd_ff <= stk[stk_ra];
   end

   // Low product of the two top entries
   always_ff @(posedge clock) begin
      prod_ff <= tos_ff * stk_rd_ff;
   end

   assign sts.mul_go     = (op_ff == OP_MUL) && !halt_ff && (count_ff >= CW'(2));
   assign sts.clear_done = (clr_ff == AW'(MEM_WORDS - 1));

   assign rsp_result_value = $signed(res_value_ff);
   assign rsp_stack_depth  = res_depth_ff;
   assign rsp_status       = res_status_ff;
   assign rsp_halted       = res_halted_ff;

endmodule

`default_nettype wire

### rtl/zasm_ctrl.sv
// Controller of the stack machine: sequences clear, fetch, execute and
// multiply steps and owns the result valid flag. Depends on zasm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zasm_ctrl
   import zasm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_EXEC,
      S_MULW
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Result register can take a new result this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Commands and next state
   always_comb begin
      state_in        = state_ff;
      cmd.latch       = 1'b0;
      cmd.commit      = 1'b0;
      cmd.use_product = 1'b0;
      cmd.clear_step  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (sts.mul_go) begin
               state_in = S_MULW;
            end else if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_MULW: begin
            cmd.use_product = 1'b1;
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Hold state and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/zasm_checker.sv
// Port-level checks for the stack machine top level, and the bind that attaches them.
// Depends on zasm_pkg and zero_address_stack_machine_unit.
`timescale 1ns / 1ps
`default_nettype none

module zasm_assertions
   import zasm_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_result_value,
   input wire logic [6:0]  rsp_stack_depth,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_halted
);

   localparam logic [6:0] FULL_DEPTH = 7'(STACK_DEPTH);

   // No result is offered right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_stack_depth) && $stable(rsp_status) && $stable(rsp_halted))
      else $error("stalled result changed");

   // The machine is not ready again in the cycle after each transfer in
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after a transfer");

   // An ignored item is only reported once halted
   a_halted_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_HALTED) |-> rsp_halted)
      else $error("halted status without halt flag");

   // Overflow only on a full stack
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OVER) |-> (rsp_stack_depth == FULL_DEPTH))
      else $error("overflow reported on a stack that is not full");

endmodule

bind zero_address_stack_machine_unit zasm_assertions #(
   .STACK_DEPTH (STACK_DEPTH)
) u_zasm_assertions (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_stack_depth  (rsp_stack_depth),
   .rsp_status       (rsp_status),
   .rsp_halted       (rsp_halted)
);

`default_nettype wire

### test/zasm_checker.sv
// Checker for the zero-address stack machine: watches both channels, predicts each result.
// Holds its own copy of the stack, data memory and halt flag; depends on zasm_pkg only.
`timescale 1ns / 1ps

module zasm_checker
   import zasm_pkg::*;
#(
   parameter int STACK_DEPTH = 64,
   parameter int MEM_WORDS   = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_type,
   input  logic [7:0]         req_mem_address,
   input  logic signed [31:0] req_load_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_result_value,
   input  logic [6:0]         rsp_stack_depth,
   input  logic [1:0]         rsp_status,
   input  logic               rsp_halted,
   output int                 fail_count,
   output int                 pending_count,
   output int                 checked_count,
   output int                 overflow_count,
   output int                 underflow_count,
   output int                 halted_count
);

   typedef struct packed {
      logic [31:0] value;
      logic [6:0]  depth;
      logic [1:0]  status;
      logic        halted;
   } machine_result_type;

   logic [31:0]        stack_words [STACK_DEPTH];
   logic [31:0]        memory_words [MEM_WORDS];
   int unsigned        word_count;
   logic               halt_seen;
   machine_result_type expected_results [$];

   // Execute one instruction on the shadow machine and form its result
   task automatic execute_instruction(input logic [2:0] op, input logic [7:0] addr_in,
                                      input logic [31:0] word_in,
                                      output machine_result_type res);
      int unsigned addr;
      logic [1:0]  st;
      logic [31:0] a;
      logic [31:0] b;
      logic        is_read;
      addr    = addr_in % MEM_WORDS;
      st      = ST_OK;
      is_read = 1'b0;
      if (op == OP_LOAD) begin
         memory_words[addr] = word_in;
      end else if (op == OP_READ) begin
         is_read = 1'b1;
      end else if (halt_seen) begin
         st = ST_HALTED;
      end else begin
         case (op)
            OP_PUSH: begin
               if (word_count >= STACK_DEPTH) begin
                  st = ST_OVER;
               end else begin
                  stack_words[word_count] = memory_words[addr];
                  word_count++;
               end
            end
            OP_POP: begin
               if (word_count == 0) begin
                  st = ST_UNDER;
               end else begin
                  word_count--;
                  memory_words[addr] = stack_words[word_count];
               end
            end
            OP_ADD, OP_MUL: begin
               if (word_count < 2) begin
                  st = ST_UNDER;
               end else begin
                  a = stack_words[word_count - 1];
                  b = stack_words[word_count - 2];
                  word_count--;
                  // keep the low 32 bits of sum or product
                  stack_words[word_count - 1] = (op == OP_ADD) ? a + b : a * b;
               end
            end
            OP_END: begin
               halt_seen = 1'b1;
            end
            default: begin
               // undefined code: no-op while running
            end
         endcase
      end
      if (is_read)
         res.value = memory_words[addr];
      else if (word_count == 0)
         res.value = 32'd0;
      else
         res.value = stack_words[word_count - 1];
      res.depth  = word_count[6:0];
      res.status = st;
      res.halted = halt_seen;
   endtask

   // Compare each result transfer with the oldest prediction, then predict new requests
   always @(posedge clock) begin
      machine_result_type predicted;
      machine_result_type oldest;
      if (reset) begin
         word_count = 0;
         halt_seen  = 1'b0;
         for (int i = 0; i < MEM_WORDS; i++)
            memory_words[i] = 32'd0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with no request outstanding");
               fail_count++;
            end else begin
               oldest = expected_results.pop_front();
               checked_count++;
               if (rsp_result_value !== oldest.value) begin
                  $error("result_value: expected %0d, actual %0d",
                         $signed(oldest.value), rsp_result_value);
                  fail_count++;
               end
               if (rsp_stack_depth !== oldest.depth) begin
                  $error("stack_depth: expected %0d, actual %0d",
                         oldest.depth, rsp_stack_depth);
                  fail_count++;
               end
               if (rsp_status !== oldest.status) begin
                  $error("status: expected %0d, actual %0d", oldest.status, rsp_status);
                  fail_count++;
               end
               if (rsp_halted !== oldest.halted) begin
                  $error("halted: expected %0d, actual %0d", oldest.halted, rsp_halted);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            execute_instruction(req_type, req_mem_address, req_load_value, predicted);
            expected_results.push_back(predicted);
            if (predicted.status == ST_OVER)
               overflow_count++;
            if (predicted.status == ST_UNDER)
               underflow_count++;
            if (predicted.status == ST_HALTED)
               halted_count++;
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

### test/testbench.sv
// Top of the stack machine testbench: clock, reset, request stimulus and the final verdict.
// Instantiates zero_address_stack_machine_unit and zasm_checker; uses zasm_pkg codes.
`timescale 1ns / 1ps

module testbench;
   import zasm_pkg::*;

   localparam int STALL_LIMIT = 2000;
   // Code with no meaning; a no-op while running
   localparam logic [2:0] OP_UNDEFINED = 3'd7;

   logic               clock;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [2:0]         req_type         = 3'd0;
   logic [7:0]         req_mem_address  = 8'd0;
   logic signed [31:0] req_load_value   = 32'sd0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic [6:0]         rsp_stack_depth;
   logic [1:0]         rsp_status;
   logic               rsp_halted;

   int fail_count;
   int pending_count;
   int checked_count;
   int overflow_count;
   int underflow_count;
   int halted_count;
   int tx_idle_pct = 24;
   int rx_idle_pct = 71;
   int stall_cycles = 0;
   int items_sent = 0;

   zero_address_stack_machine_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_mem_address  (req_mem_address),
      .req_load_value   (req_load_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_stack_depth  (rsp_stack_depth),
      .rsp_status       (rsp_status),
      .rsp_halted       (rsp_halted)
   );

   zasm_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_mem_address  (req_mem_address),
      .req_load_value   (req_load_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_stack_depth  (rsp_stack_depth),
      .rsp_status       (rsp_status),
      .rsp_halted       (rsp_halted),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .overflow_count   (overflow_count),
      .underflow_count  (underflow_count),
      .halted_count     (halted_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Count cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Offer one instruction after a random gap and hold it until the transfer
   task automatic send_instruction(input logic [2:0] op, input logic [7:0] addr,
                                   input logic [31:0] word);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < tx_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= op;
      req_mem_address <= addr;
      req_load_value  <= word;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   // Random instructions: first half drives the stack toward full, second half drains it
   task automatic run_random_phase(input int count);
      int          pick;
      logic [2:0]  op;
      logic [7:0]  addr;
      logic [31:0] word;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (n < count / 2) begin
            if (pick < 75)      op = OP_PUSH;
            else if (pick < 80) op = OP_POP;
            else if (pick < 85) op = OP_ADD;
            else if (pick < 90) op = OP_MUL;
            else if (pick < 97) op = OP_LOAD;
            else if (pick < 99) op = OP_READ;
            else                op = OP_UNDEFINED;
         end else begin
            if (pick < 15)      op = OP_PUSH;
            else if (pick < 40) op = OP_POP;
            else if (pick < 62) op = OP_ADD;
            else if (pick < 84) op = OP_MUL;
            else if (pick < 95) op = OP_LOAD;
            else if (pick < 99) op = OP_READ;
            else                op = OP_UNDEFINED;
         end
         // mostly a small address pool so pushes see earlier loads and pops
         if ($urandom_range(0, 99) < 70)
            addr = 8'($urandom_range(0, 15));
         else
            addr = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 9))
            0:       word = 32'h7FFF_FFFF;
            1:       word = 32'h8000_0000;
            2:       word = 32'hFFFF_FFFF;
            3:       word = $urandom_range(0, 3);
            default: word = $urandom;
         endcase
         send_instruction(op, addr, word);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: cleared memory, underflows, extreme words, wrap of product
      send_instruction(OP_READ, 8'd0,   32'hFFFF_FFFF);
      send_instruction(OP_POP,  8'd255, 32'h0000_0000);
      send_instruction(OP_ADD,  8'd0,   32'h8000_0000);
      send_instruction(OP_LOAD, 8'd0,   32'h7FFF_FFFF);
      send_instruction(OP_LOAD, 8'd255, 32'h8000_0000);
      send_instruction(OP_LOAD, 8'd1,   32'hFFFF_FFFF);
      send_instruction(OP_PUSH, 8'd0,   32'h0000_0000);
      send_instruction(OP_MUL,  8'd0,   32'hFFFF_FFFF);
      send_instruction(OP_PUSH, 8'd255, 32'h7FFF_FFFF);
      send_instruction(OP_ADD,  8'd0,   32'h0000_0000);
      send_instruction(OP_PUSH, 8'd1,   32'h0000_0000);
      send_instruction(OP_MUL,  8'd0,   32'h0000_0000);
      send_instruction(OP_POP,  8'd128, 32'h0000_0000);
      send_instruction(OP_READ, 8'd128, 32'h0000_0000);
      send_instruction(OP_UNDEFINED, 8'd255, 32'hFFFF_FFFF);
      send_instruction(OP_PUSH, 8'd255, 32'h0000_0000);
      send_instruction(OP_PUSH, 8'd255, 32'h0000_0000);
      send_instruction(OP_MUL,  8'd0,   32'h0000_0000);
      send_instruction(OP_PUSH, 8'd1,   32'h0000_0000);
      send_instruction(OP_ADD,  8'd0,   32'h0000_0000);
      send_instruction(OP_POP,  8'd2,   32'h0000_0000);
      send_instruction(OP_READ, 8'd2,   32'h0000_0000);

      run_random_phase(250);
      tx_idle_pct <= 71;
      rx_idle_pct <= 24;
      run_random_phase(250);
      tx_idle_pct <= 0;
      rx_idle_pct <= 0;
      run_random_phase(250);

      // Halt, then every code once more: only load and read still act
      send_instruction(OP_END,  8'd3,   32'h0000_0000);
      send_instruction(OP_PUSH, 8'd1,   32'h0000_0000);
      send_instruction(OP_POP,  8'd4,   32'h0000_0000);
      send_instruction(OP_ADD,  8'd0,   32'h0000_0000);
      send_instruction(OP_MUL,  8'd0,   32'h0000_0000);
      send_instruction(OP_END,  8'd0,   32'h0000_0000);
      send_instruction(OP_UNDEFINED, 8'd0, 32'h0000_0000);
      send_instruction(OP_LOAD, 8'd4,   32'h1234_5678);
      send_instruction(OP_READ, 8'd4,   32'h0000_0000);
      req_valid <= 1'b0;

      // Drain outstanding results, then let the pipeline settle
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d instructions, checked %0d results across three idle patterns.",
               items_sent, checked_count);
      $display("Overflows %0d, underflows %0d, ignored while halted %0d.",
               overflow_count, underflow_count, halted_count);
      if (pending_count != 0)
         $error("%0d predicted results never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### zero_address_stack_machine_unit.f
rtl/zasm_pkg.sv
rtl/zasm_datapath.sv
rtl/zasm_ctrl.sv
rtl/zero_address_stack_machine_unit.sv
rtl/zasm_checker.sv
test/zasm_checker.sv
test/testbench.sv
